### rtl/core/cmta_pkg.sv
// ----------------------------------------------------------------------------
// cmta_pkg: shared types and constants for the color markup converter
// Request structs, action encoding between front and back, character codes.
// ----------------------------------------------------------------------------
package cmta_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ENABLE   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_SUPPRESS = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BEEP_SUPPRESS  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIP_MODE     = 4'd3;

  // action kinds
  localparam logic [2:0] K_LIT   = 3'd0;
  localparam logic [2:0] K_BEEP  = 3'd1;
  localparam logic [2:0] K_LINE  = 3'd2;
  localparam logic [2:0] K_ESC1  = 3'd3;
  localparam logic [2:0] K_BOTH  = 3'd4;
  localparam logic [2:0] K_RESET = 3'd5;
  localparam logic [2:0] K_BLINK = 3'd6;

  // characters
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BELL  = 8'h07;

  localparam logic [4:0] LEN_ESC1  = 5'd7;
  localparam logic [4:0] LEN_BOTH  = 5'd10;
  localparam logic [4:0] LEN_RESET = 5'd9;
  localparam logic [4:0] LEN_BLINK = 5'd4;
  localparam logic [4:0] LEN_CRLF  = 5'd2;
  localparam logic [4:0] LEN_INDENT = 5'd19;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_result;
  } out_item_t;

  typedef struct packed {
    logic color_enable;
    logic blink_suppress;
    logic beep_suppress;
    logic strip_mode;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // one decided piece of output, expanded byte by byte in the back end
  typedef struct packed {
    logic [2:0]      kind;
    logic [4:0]      len;
    logic            eot;
    logic [3:0][7:0] lit;
    logic            attr_bold;
    logic [2:0]      fdig;
    logic [2:0]      bdig;
    logic            bg;
  } action_t;

  // {valid, color digit}
  function automatic logic [3:0] color_code(input logic [7:0] x);
    logic [3:0] r;
    r = 4'd0;
    if (x[7:6] == 2'b01) begin
      case (x[4:0])
        5'd2:    r = {1'b1, 3'd4};
        5'd3:    r = {1'b1, 3'd6};
        5'd7:    r = {1'b1, 3'd2};
        5'd12:   r = {1'b1, 3'd0};
        5'd13:   r = {1'b1, 3'd5};
        5'd18:   r = {1'b1, 3'd1};
        5'd23:   r = {1'b1, 3'd7};
        5'd25:   r = {1'b1, 3'd3};
        default: r = 4'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] digit_char(input logic [2:0] d);
    return CH_ZERO | {5'd0, d};
  endfunction

  function automatic logic [7:0] action_byte(input action_t a, input logic [4:0] idx);
    logic [7:0] r;
    logic [7:0] attr;
    r = 8'h00;
    attr = a.attr_bold ? CH_ONE : CH_ZERO;
    case (a.kind)
      K_LIT:  r = a.lit[idx[1:0]];
      K_BEEP: r = CH_BELL;
      K_LINE: begin
        case (idx)
          5'd0:    r = CH_CR;
          5'd1:    r = CH_LF;
          default: r = CH_SPACE;
        endcase
      end
      K_ESC1: begin
        case (idx)
          5'd0:    r = CH_ESC;
          5'd1:    r = CH_LBR;
          5'd2:    r = attr;
          5'd3:    r = CH_SEMI;
          5'd4:    r = a.bg ? CH_FOUR : CH_THREE;
          5'd5:    r = digit_char(a.fdig);
          default: r = CH_M;
        endcase
      end
      K_BOTH: begin
        case (idx)
          5'd0:    r = CH_ESC;
          5'd1:    r = CH_LBR;
          5'd2:    r = attr;
          5'd3:    r = CH_SEMI;
          5'd4:    r = CH_FOUR;
          5'd5:    r = digit_char(a.bdig);
          5'd6:    r = CH_SEMI;
          5'd7:    r = CH_THREE;
          5'd8:    r = digit_char(a.fdig);
          default: r = CH_M;
        endcase
      end
      K_RESET: begin
        case (idx)
          5'd0:    r = CH_ESC;
          5'd1:    r = CH_LBR;
          5'd2:    r = CH_FOUR;
          5'd3:    r = CH_ZERO;
          5'd4:    r = CH_M;
          5'd5:    r = CH_ESC;
          5'd6:    r = CH_LBR;
          5'd7:    r = CH_ZERO;
          default: r = CH_M;
        endcase
      end
      K_BLINK: begin
        case (idx)
          5'd0:    r = CH_ESC;
          5'd1:    r = CH_LBR;
          5'd2:    r = CH_FIVE;
          default: r = CH_M;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/cmta_front.sv
// ----------------------------------------------------------------------------
// cmta_front: markup classifier
// Holds unfinished code bytes and turns each request into at most one action.
// ----------------------------------------------------------------------------
module cmta_front (
  input  logic                clk,
  input  logic                rst,
  input  cmta_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  cmta_pkg::in_item_t  in_item,
  input  cmta_pkg::q_status_t q_status,
  output logic                push,
  output cmta_pkg::action_t   push_data
);

  logic [1:0]      cnt;
  logic [1:0]      cnt_next;
  logic [2:0][7:0] pend;
  logic [3:0][7:0] buf_b;
  logic [7:0]      b;
  logic            eot;
  logic            esc;
  logic            accept;
  logic [3:0]      cd;
  logic [3:0]      fd;
  cmta_pkg::action_t act;

  assign b        = in_item.in_byte;
  assign eot      = in_item.end_of_text;
  assign esc      = !cfg.strip_mode && cfg.color_enable;
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign cd       = cmta_pkg::color_code(b);
  assign fd       = cmta_pkg::color_code(pend[2]);

  // held bytes followed by the new byte
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      buf_b[j] = (j < int'(cnt)) ? pend[j] : b;
    end
  end

  always_comb begin
    logic [4:0] base;
    logic       fail;
    logic       hold_all;
    base     = 5'd0;
    fail     = 1'b0;
    hold_all = 1'b0;
    act      = '0;
    act.kind = cmta_pkg::K_LIT;
    act.lit  = buf_b;
    act.eot  = eot;
    cnt_next = 2'd0;
    case (cnt)
      2'd0: begin
        if (b == cmta_pkg::CH_AMP) hold_all = 1'b1;
        else act.len = 5'd1;
      end
      2'd1: begin
        if (b == cmta_pkg::CH_AMP) begin
          act.len = 5'd1;
        end else if (b == cmta_pkg::CH_PLUS || b == cmta_pkg::CH_MINUS ||
                     b == cmta_pkg::CH_EQ) begin
          hold_all = 1'b1;
        end else if (b == cmta_pkg::CH_STAR) begin
          if (esc) begin
            act.kind = cmta_pkg::K_RESET;
            act.len  = cmta_pkg::LEN_RESET;
          end
        end else if (b == cmta_pkg::CH_B) begin
          if (esc && !cfg.blink_suppress) begin
            act.kind = cmta_pkg::K_BLINK;
            act.len  = cmta_pkg::LEN_BLINK;
          end
        end else if (b == cmta_pkg::CH_HASH) begin
          if (!cfg.strip_mode && !cfg.beep_suppress) begin
            act.kind = cmta_pkg::K_BEEP;
            act.len  = 5'd1;
          end
        end else if ((b == cmta_pkg::CH_GT || b == cmta_pkg::CH_SLASH) &&
                     !cfg.strip_mode) begin
          act.kind = cmta_pkg::K_LINE;
          act.len  = (b == cmta_pkg::CH_GT) ? cmta_pkg::LEN_INDENT : cmta_pkg::LEN_CRLF;
        end else begin
          act.len = 5'd2;
        end
      end
      2'd2: begin
        if (!cd[3]) begin
          fail = 1'b1;
          base = 5'd2;
        end else if (pend[1] == cmta_pkg::CH_EQ) begin
          hold_all = 1'b1;
        end else if (esc) begin
          act.kind      = cmta_pkg::K_ESC1;
          act.len       = cmta_pkg::LEN_ESC1;
          act.attr_bold = !b[5];
          act.fdig      = cd[2:0];
          act.bg        = (pend[1] == cmta_pkg::CH_MINUS);
        end
      end
      default: begin
        if (!cd[3]) begin
          fail = 1'b1;
          base = 5'd3;
        end else if (esc) begin
          act.kind      = cmta_pkg::K_BOTH;
          act.len       = cmta_pkg::LEN_BOTH;
          act.attr_bold = !pend[2][5];
          act.fdig      = fd[2:0];
          act.bdig      = cd[2:0];
        end
      end
    endcase

    // unfinished code: keep it, or flush it literally at end of string
    if (hold_all) begin
      if (eot) act.len = {3'd0, cnt} + 5'd1;
      else cnt_next = cnt + 2'd1;
    end

    // failed code: '&' and the rescanned bytes, a trailing '&' starts a new code
    if (fail) begin
      if (b == cmta_pkg::CH_AMP && !eot) begin
        act.len  = base;
        cnt_next = 2'd1;
      end else begin
        act.len = base + 5'd1;
      end
    end
  end

  assign push      = accept && (act.len != 5'd0 || eot);
  assign push_data = act;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= buf_b[2:0];
    end
  end

  a_pend_starts_amp: assert property (@(posedge clk) disable iff (rst)
    (cnt != 2'd0) |-> (pend[0] == cmta_pkg::CH_AMP))
    else $error("held code does not start with an ampersand");

  a_full_hold_is_both: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd3) |-> (pend[1] == cmta_pkg::CH_EQ && fd[3]))
    else $error("three held bytes that are not an unfinished two-color code");

endmodule

### rtl/core/cmta_queue.sv
// ----------------------------------------------------------------------------
// cmta_queue: action queue
// Small FIFO between the classifier and the expander.
// ----------------------------------------------------------------------------
module cmta_queue #(
  parameter int DEPTH = cmta_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cmta_pkg::action_t   push_data,
  input  logic                pop,
  output cmta_pkg::action_t   head,
  output cmta_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  cmta_pkg::action_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == FULL);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full && !pop))
    else $error("push into a full action queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("pop from an empty action queue");

endmodule

### rtl/core/cmta_back.sv
// ----------------------------------------------------------------------------
// cmta_back: action expander
// Emits queued action bytes to the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module cmta_back (
  input  logic                clk,
  input  logic                rst,
  input  cmta_pkg::action_t   head,
  input  cmta_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output cmta_pkg::out_item_t out_item
);

  cmta_pkg::action_t cur;
  logic              cur_valid;
  logic [4:0]        idx;
  logic              last;
  logic              adv;
  logic              empty_item;

  assign empty_item = (cur.len == 5'd0);
  assign last       = empty_item || (idx == cur.len - 5'd1);
  assign adv        = cur_valid && (!out_valid || !out_stall);
  assign pop        = !q_status.empty && (!cur_valid || (adv && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= 5'd0;
    end else begin
      if (adv) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 5'd0;
      end else if (adv) begin
        if (last) cur_valid <= 1'b0;
        else idx <= idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (adv) begin
      out_item.out_byte      <= empty_item ? 8'h00 : cmta_pkg::action_byte(cur, idx);
      out_item.has_byte      <= !empty_item;
      out_item.end_of_result <= cur.eot && last;
    end
  end

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.has_byte) |-> out_item.end_of_result)
    else $error("byteless result that does not end a string");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !empty_item) |-> (idx < cur.len))
    else $error("expansion index past the action length");

endmodule

### rtl/core/color_markup_to_ansi_top.sv
// ----------------------------------------------------------------------------
// color_markup_to_ansi_top: ampersand markup to ANSI escape converter
// Rewrites a byte stream, expanding color and control codes.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item) takes one text byte per
// request, with end_of_text on the last byte of a string. Output channel
// (out_valid / out_stall / out_item) gives one rewritten byte per request;
// has_byte is 0 only on an end-only request, end_of_result marks the last
// request of a string. Configuration writes (cfg_valid / cfg_ready, always
// ready) set the four mode bits; the user must make them while the block is
// idle, which the block itself does not enforce. The result of an input
// byte is registered in the action queue, the expander's current action and
// the output register. Input is taken every cycle while the action queue has
// room. Output runs at one byte per cycle while out_stall is low: a code
// expands to up to 19 bytes, which hold the expander, and the queue of
// QUEUE_DEPTH actions lets input keep flowing in the meantime. Reset clears
// the held code bytes, the queue and the mode bits. While out_stall is high
// the output request holds and, once the queue fills, in_stall rises.
// ----------------------------------------------------------------------------
module color_markup_to_ansi_top #(
  parameter int QUEUE_DEPTH = cmta_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cmta_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cmta_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cmta_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic                               cfg_data
);

  cmta_pkg::cfg_t      cfg;
  cmta_pkg::q_status_t q_status;
  cmta_pkg::action_t   push_data;
  cmta_pkg::action_t   head;
  logic                push;
  logic                pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cmta_pkg::REG_COLOR_ENABLE:   cfg.color_enable   <= cfg_data;
        cmta_pkg::REG_BLINK_SUPPRESS: cfg.blink_suppress <= cfg_data;
        cmta_pkg::REG_BEEP_SUPPRESS:  cfg.beep_suppress  <= cfg_data;
        cmta_pkg::REG_STRIP_MODE:     cfg.strip_mode     <= cfg_data;
        default: ;
      endcase
    end
  end

  cmta_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  cmta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  cmta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### test/color_markup_to_ansi_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_markup_to_ansi_top_test: regression for the markup to ANSI converter
// Feeds byte strings of markup codes, broken codes and noise through several
// mode settings, predicts the rewritten byte stream and checks every output
// request in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
localparam int         MOST_RESULTS  = 19;
localparam int         INDENT_SPACES = 17;
localparam int         REPORT_LIMIT  = 10;
localparam logic [7:0] LOWER_FIRST   = 8'h60;

class ansi_scoreboard;
  cmta_pkg::cfg_t      mode;
  logic [1:0]          held_count;
  logic [7:0]          held_bytes [3];
  cmta_pkg::out_item_t ansi_due [$];
  cmta_pkg::out_item_t fresh [$];
  int                  mismatches;

  function new();
    mode = '0;
    held_count = 2'd0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [cmta_pkg::CFG_INDEX_W-1:0] index, logic data);
    case (index)
      cmta_pkg::REG_COLOR_ENABLE:   mode.color_enable = data;
      cmta_pkg::REG_BLINK_SUPPRESS: mode.blink_suppress = data;
      cmta_pkg::REG_BEEP_SUPPRESS:  mode.beep_suppress = data;
      cmta_pkg::REG_STRIP_MODE:     mode.strip_mode = data;
      default: ;
    endcase
  endfunction

  function int outstanding();
    return ansi_due.size();
  endfunction

  // bit 3 set when x is a color letter, low bits give its digit
  function logic [3:0] letter_digit(logic [7:0] x);
    string      letters;
    int         n;
    logic [7:0] folded;
    letters = "lrgybmcw";
    letter_digit = 4'd0;
    if (x[7:6] == 2'b01) begin
      folded = x | 8'h20;
      for (n = 0; n < 8; n++)
        if (folded == letters[n]) letter_digit = {1'b1, 3'(n)};
    end
  endfunction

  function void emit(logic [7:0] b);
    cmta_pkg::out_item_t r;
    if (fresh.size() < MOST_RESULTS) begin
      r.out_byte = b;
      r.has_byte = 1'b1;
      r.end_of_result = 1'b0;
      fresh.push_back(r);
    end
  endfunction

  function void note_request(cmta_pkg::in_item_t req);
    logic [7:0]          window [4];
    int                  len, pos, n, j;
    logic                stuck, esc;
    logic [7:0]          code, attr;
    logic [3:0]          fg, bg;
    cmta_pkg::out_item_t tail;
    fresh.delete();
    esc = !mode.strip_mode && mode.color_enable;
    for (n = 0; n < held_count; n++) window[n] = held_bytes[n];
    window[held_count] = req.in_byte;
    len = held_count + 1;
    pos = 0;
    stuck = 1'b0;
    while (pos < len && !stuck) begin
      if (window[pos] != cmta_pkg::CH_AMP) begin
        emit(window[pos]);
        pos++;
      end else if (pos + 1 >= len) begin
        stuck = 1'b1;
      end else begin
        code = window[pos + 1];
        if (code == cmta_pkg::CH_AMP) begin
          emit(cmta_pkg::CH_AMP);
          pos += 2;
        end else if (code == cmta_pkg::CH_PLUS || code == cmta_pkg::CH_MINUS) begin
          if (pos + 2 >= len) begin
            stuck = 1'b1;
          end else begin
            fg = letter_digit(window[pos + 2]);
            if (!fg[3]) begin
              emit(cmta_pkg::CH_AMP);
              pos++;
            end else begin
              if (esc) begin
                attr = (window[pos + 2] >= LOWER_FIRST) ? cmta_pkg::CH_ZERO : cmta_pkg::CH_ONE;
                emit(cmta_pkg::CH_ESC); emit(cmta_pkg::CH_LBR);
                emit(attr); emit(cmta_pkg::CH_SEMI);
                emit((code == cmta_pkg::CH_MINUS) ? cmta_pkg::CH_FOUR : cmta_pkg::CH_THREE);
                emit(cmta_pkg::CH_ZERO | {5'd0, fg[2:0]});
                emit(cmta_pkg::CH_M);
              end
              pos += 3;
            end
          end
        end else if (code == cmta_pkg::CH_EQ) begin
          if (pos + 2 >= len) begin
            stuck = 1'b1;
          end else begin
            fg = letter_digit(window[pos + 2]);
            if (!fg[3]) begin
              emit(cmta_pkg::CH_AMP);
              pos++;
            end else if (pos + 3 >= len) begin
              stuck = 1'b1;
            end else begin
              bg = letter_digit(window[pos + 3]);
              if (!bg[3]) begin
                emit(cmta_pkg::CH_AMP);
                pos++;
              end else begin
                if (esc) begin
                  attr = (window[pos + 2] >= LOWER_FIRST) ? cmta_pkg::CH_ZERO
                                                          : cmta_pkg::CH_ONE;
                  emit(cmta_pkg::CH_ESC); emit(cmta_pkg::CH_LBR);
                  emit(attr); emit(cmta_pkg::CH_SEMI);
                  emit(cmta_pkg::CH_FOUR); emit(cmta_pkg::CH_ZERO | {5'd0, bg[2:0]});
                  emit(cmta_pkg::CH_SEMI); emit(cmta_pkg::CH_THREE);
                  emit(cmta_pkg::CH_ZERO | {5'd0, fg[2:0]}); emit(cmta_pkg::CH_M);
                end
                pos += 4;
              end
            end
          end
        end else if (code == cmta_pkg::CH_STAR) begin
          if (esc) begin
            emit(cmta_pkg::CH_ESC); emit(cmta_pkg::CH_LBR); emit(cmta_pkg::CH_FOUR);
            emit(cmta_pkg::CH_ZERO); emit(cmta_pkg::CH_M);
            emit(cmta_pkg::CH_ESC); emit(cmta_pkg::CH_LBR); emit(cmta_pkg::CH_ZERO);
            emit(cmta_pkg::CH_M);
          end
          pos += 2;
        end else if (code == cmta_pkg::CH_B) begin
          if (esc && !mode.blink_suppress) begin
            emit(cmta_pkg::CH_ESC); emit(cmta_pkg::CH_LBR);
            emit(cmta_pkg::CH_FIVE); emit(cmta_pkg::CH_M);
          end
          pos += 2;
        end else if (code == cmta_pkg::CH_HASH) begin
          if (!mode.strip_mode && !mode.beep_suppress) emit(cmta_pkg::CH_BELL);
          pos += 2;
        end else if ((code == cmta_pkg::CH_GT || code == cmta_pkg::CH_SLASH) &&
                     !mode.strip_mode) begin
          emit(cmta_pkg::CH_CR);
          emit(cmta_pkg::CH_LF);
          if (code == cmta_pkg::CH_GT)
            for (n = 0; n < INDENT_SPACES; n++) emit(cmta_pkg::CH_SPACE);
          pos += 2;
        end else begin
          emit(cmta_pkg::CH_AMP);
          pos++;
        end
      end
    end

    n = 0;
    for (j = pos; j < len && n < 3; j++) begin
      held_bytes[n] = window[j];
      n++;
    end
    held_count = n[1:0];

    if (req.end_of_text) begin
      for (n = 0; n < held_count; n++) emit(held_bytes[n]);
      held_count = 2'd0;
      if (fresh.size() == 0) begin
        tail = '0;
        tail.end_of_result = 1'b1;
      end else begin
        tail = fresh.pop_back();
        tail.end_of_result = 1'b1;
      end
      fresh.push_back(tail);
    end
    for (n = 0; n < fresh.size(); n++) ansi_due.push_back(fresh[n]);
  endfunction

  function void check_result(cmta_pkg::out_item_t got);
    cmta_pkg::out_item_t want;
    if (ansi_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected request: byte %h has %b end %b",
                 got.out_byte, got.has_byte, got.end_of_result);
    end else begin
      want = ansi_due.pop_front();
      if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
          got.end_of_result !== want.end_of_result) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: expected byte %h has %b end %b, got byte %h has %b end %b",
                   want.out_byte, want.has_byte, want.end_of_result,
                   got.out_byte, got.has_byte, got.end_of_result);
      end
    end
  endfunction
endclass

module color_markup_to_ansi_top_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 7;
  localparam int PHASE_BYTES   = 20;
  localparam int HOLD_CYCLES   = 150;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  cmta_pkg::in_item_t               in_item = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  cmta_pkg::out_item_t              out_item;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [cmta_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic                             cfg_data = 1'b0;

  ansi_scoreboard board = new();
  logic [7:0]     text_q [$];
  logic           quiet = 1'b0;
  int             hold_left = 0;
  int             cycles = 0;
  cmta_pkg::cfg_t phase_modes [PHASES];

  color_markup_to_ansi_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("color_markup_to_ansi_top regression: fail");
      $finish;
    end
  end

  // receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_item);
  end

  task automatic send_item(logic [7:0] value, logic last);
    cmta_pkg::in_item_t req;
    req.in_byte = value;
    req.end_of_text = last;
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req);
    @(negedge clk);
  endtask

  // close ends the string on the last byte so nothing stays held
  task automatic send_text(logic close);
    logic [7:0] value;
    logic       last;
    while (text_q.size() > 0) begin
      value = text_q.pop_front();
      last = (close && text_q.size() == 0) || ($urandom_range(0, 9) == 0);
      send_item(value, last);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // flags shared with the receiver change at the rising edge only
  task automatic set_quiet(logic on);
    in_valid <= 1'b0;
    @(posedge clk);
    quiet = on;
    @(negedge clk);
  endtask

  task automatic start_hold(int span);
    in_valid <= 1'b0;
    @(posedge clk);
    hold_left = span;
    @(negedge clk);
  endtask

  task automatic set_mode(cmta_pkg::cfg_t m);
    logic [cmta_pkg::CFG_INDEX_W-1:0] idx [5];
    logic                             val [5];
    int                               r;
    idx[0] = cmta_pkg::CFG_INDEX_W'($urandom_range(cmta_pkg::REG_STRIP_MODE + 1,
                                                   (1 << cmta_pkg::CFG_INDEX_W) - 1));
    val[0] = 1'($urandom);
    idx[1] = cmta_pkg::REG_COLOR_ENABLE;   val[1] = m.color_enable;
    idx[2] = cmta_pkg::REG_BLINK_SUPPRESS; val[2] = m.blink_suppress;
    idx[3] = cmta_pkg::REG_BEEP_SUPPRESS;  val[3] = m.beep_suppress;
    idx[4] = cmta_pkg::REG_STRIP_MODE;     val[4] = m.strip_mode;
    for (r = 0; r < 5; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[r];
      cfg_data <= val[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.set_reg(idx[r], val[r]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_letter();
    string      letters = "lrgybmcw";
    logic [7:0] c;
    c = letters[$urandom_range(0, 7)];
    if ($urandom_range(0, 1)) c = c & 8'hDF;
    return c;
  endfunction

  function automatic void push_str(string s);
    int n;
    for (n = 0; n < s.len(); n++) text_q.push_back(s[n]);
  endfunction

  // mostly well formed codes with random content, some broken ones and noise
  task automatic add_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      text_q.push_back(8'($urandom));
    end else if (pick < 36) begin
      text_q.push_back(cmta_pkg::CH_AMP); text_q.push_back(cmta_pkg::CH_AMP);
    end else if (pick < 48) begin
      text_q.push_back(cmta_pkg::CH_AMP);
      text_q.push_back($urandom_range(0, 1) ? cmta_pkg::CH_PLUS : cmta_pkg::CH_MINUS);
      text_q.push_back(pick_letter());
    end else if (pick < 57) begin
      text_q.push_back(cmta_pkg::CH_AMP); text_q.push_back(cmta_pkg::CH_EQ);
      text_q.push_back(pick_letter()); text_q.push_back(pick_letter());
    end else if (pick < 62) begin
      text_q.push_back(cmta_pkg::CH_AMP); text_q.push_back(cmta_pkg::CH_STAR);
    end else if (pick < 67) begin
      text_q.push_back(cmta_pkg::CH_AMP); text_q.push_back(cmta_pkg::CH_B);
    end else if (pick < 72) begin
      text_q.push_back(cmta_pkg::CH_AMP); text_q.push_back(cmta_pkg::CH_HASH);
    end else if (pick < 78) begin
      text_q.push_back(cmta_pkg::CH_AMP);
      text_q.push_back($urandom_range(0, 1) ? cmta_pkg::CH_GT : cmta_pkg::CH_SLASH);
    end else if (pick < 84) begin
      text_q.push_back(cmta_pkg::CH_AMP); text_q.push_back(8'($urandom));
    end else if (pick < 90) begin
      text_q.push_back(cmta_pkg::CH_AMP);
      text_q.push_back($urandom_range(0, 1) ? cmta_pkg::CH_PLUS : cmta_pkg::CH_MINUS);
      text_q.push_back(8'($urandom));
    end else if (pick < 95) begin
      text_q.push_back(cmta_pkg::CH_AMP); text_q.push_back(cmta_pkg::CH_EQ);
      text_q.push_back(pick_letter()); text_q.push_back(8'($urandom));
    end else begin
      // code cut short, usually followed by another code
      text_q.push_back(cmta_pkg::CH_AMP);
      if ($urandom_range(0, 1)) text_q.push_back(cmta_pkg::CH_EQ);
    end
  endtask

  initial begin
    int p;
    // mode bits in order: color, blink suppress, beep suppress, strip
    phase_modes[0] = 4'b1000;
    phase_modes[1] = 4'b0000;
    phase_modes[2] = 4'b1110;
    phase_modes[3] = 4'b1001;
    phase_modes[4] = 4'b1111;
    phase_modes[5] = 4'b0101;
    phase_modes[6] = 4'($urandom);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every code, failed codes, zero and all-ones bytes, flush at end
    set_mode(4'b1000);
    push_str("&&&+R&-b&=Wl&*&B&#&>&/&q");
    text_q.push_back(cmta_pkg::CH_AMP);
    text_q.push_back(cmta_pkg::CH_PLUS);
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(cmta_pkg::CH_AMP);
    text_q.push_back(cmta_pkg::CH_EQ);
    send_text(1'b1);

    // consumed reset code ending the string gives an end-only request
    wait_quiet();
    set_mode(4'b0000);
    text_q.push_back(cmta_pkg::CH_AMP);
    text_q.push_back(cmta_pkg::CH_STAR);
    send_text(1'b1);

    for (p = 0; p < PHASES; p++) begin
      wait_quiet();
      set_mode(phase_modes[p]);
      if (p == 2) set_quiet(1'b1);
      if (p == 3) start_hold(HOLD_CYCLES);
      while (text_q.size() < PHASE_BYTES) add_token();
      send_text(1'b1);
      if (p == 2) set_quiet(1'b0);
    end

    wait_quiet();
    if (board.mismatches == 0 && board.outstanding() == 0)
      $display("color_markup_to_ansi_top regression: pass");
    else
      $display("color_markup_to_ansi_top regression: fail");
    $finish;
  end

endmodule
